// File: src/gdsf_pkg.sv
package gdsf_pkg;

   localparam int ENTRIES   = 64;
   localparam int SLOT_W    = $clog2(ENTRIES);
   localparam int CNT_W     = SLOT_W + 1;
   localparam int FRAC_BITS = 32;
   localparam int PRIO_W    = 64;
   localparam int ID_W      = 64;
   localparam int SIZE_W    = 32;
   localparam int HITS_W    = 32;
   localparam int BYTES_W   = 40;
   localparam int EVICT_W   = 7;
   localparam int DIVQ_W    = 64;
   localparam int DIVN_W    = HITS_W + FRAC_BITS;

   localparam logic [0:0] CSR_CAPACITY = 1'd0;
   localparam logic [0:0] CSR_POLICY   = 1'd1;

   typedef enum logic [1:0] {
      POL_GD   = 2'd0,
      POL_GDS  = 2'd1,
      POL_GDSF = 2'd2
   } policy_type;

   typedef struct packed {
      logic              start;
      logic [HITS_W-1:0] count;
      logic [SIZE_W-1:0] size;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [DIVQ_W-1:0] quotient;
   } div_rsp_type;

endpackage

// File: src/greedy_dual_size_freq_cache_core.sv
// Channel | Ports             | Item
// req     | req_tvalid/tready | object_id, object_size
// rsp     | rsp_tvalid/tready | hit, admitted, evicted_count, bytes_in_use
// csr     | csr_valid/ready   | register index, write data
// A request walks the 64 slots once for a hit (one slot read per cycle),
// then for a miss walks them again per eviction round; H comes from a serial
// divider, skipped in GreedyDual mode.
// Reset is synchronous; slot valid bits, clock and usage clear at once.
// req_tready is low from acceptance until the result has been taken, and while
// a register write is offered.
module greedy_dual_size_freq_cache_core
   import gdsf_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   input  logic [95:0]          req_tdata,  // object_id[63:0], object_size[95:64]
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [55:0]          rsp_tdata,  // hit[0], admitted[1], evicted_count[8:2],
                                            // bytes_in_use[48:9], zero fill
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [0:0]           csr_index,
   input  logic [BYTES_W-1:0]   csr_data
);

   typedef enum logic [3:0] {
      S_IDLE, S_HSCAN, S_HWAIT, S_HDIV, S_HWRITE,
      S_VSCAN, S_VWAIT, S_DECIDE, S_IDIV, S_IWRITE, S_RESP
   } state_type;

   logic [ID_W-1:0]   mem_obj   [ENTRIES];
   logic [SIZE_W-1:0] mem_bytes [ENTRIES];
   logic [PRIO_W-1:0] mem_prio  [ENTRIES];
   logic [HITS_W-1:0] mem_hits  [ENTRIES];
   logic [ENTRIES-1:0] valid_ff;

   state_type          state_ff;
   logic [CNT_W-1:0]   idx_ff;
   logic [SLOT_W-1:0]  rd_ff;
   logic               rdv_ff;
   logic [SLOT_W-1:0]  rd_slot;
   logic [ID_W-1:0]    r_obj;
   logic [SIZE_W-1:0]  r_bytes;
   logic [PRIO_W-1:0]  r_prio;
   logic [HITS_W-1:0]  r_hits;
   logic [ID_W-1:0]    id_ff;
   logic [SIZE_W-1:0]  size_ff;
   logic [PRIO_W-1:0]  clk_ff;
   logic [BYTES_W-1:0] used_ff, cap_ff;
   policy_type         pol_ff;
   logic               hit_ff, adm_ff;
   logic [CNT_W-1:0]   evict_ff;
   logic [SLOT_W-1:0]  slot_ff;
   logic [SIZE_W-1:0]  hbytes_ff;
   logic [HITS_W-1:0]  hhits_ff;
   logic               found_ff, vfound_ff;
   logic [SLOT_W-1:0]  vic_ff;
   logic [PRIO_W-1:0]  vprio_ff;
   logic [SIZE_W-1:0]  vbytes_ff;
   logic               free_ok_ff;
   logic [SLOT_W-1:0]  free_ff;
   div_req_type        div_req;
   div_rsp_type        div_rsp;
   logic [PRIO_W-1:0]  h_val;
   logic [PRIO_W:0]    psum;
   logic [PRIO_W-1:0]  new_prio;
   logic [BYTES_W:0]   need;
   logic [1:0]         cfg_pol;

   gdsf_div u_div (.clock(clock), .reset(reset), .div_req(div_req), .div_rsp(div_rsp));

   assign rd_slot = idx_ff[SLOT_W-1:0];
   always_ff @(posedge clock) begin
      r_obj   <= mem_obj[rd_slot];
      r_bytes <= mem_bytes[rd_slot];
      r_prio  <= mem_prio[rd_slot];
      r_hits  <= mem_hits[rd_slot];
   end

   always_comb begin
      case (pol_ff)
         POL_GD:  h_val = PRIO_W'(1) << FRAC_BITS;
         default: h_val = div_rsp.quotient;
      endcase
      psum     = {1'b0, clk_ff} + {1'b0, h_val};
      new_prio = psum[PRIO_W] ? '1 : psum[PRIO_W-1:0];
      need     = {1'b0, used_ff} + (BYTES_W+1)'(size_ff);
      cfg_pol  = (csr_data[1:0] == 2'd3) ? 2'd2 : csr_data[1:0];
   end

   always_comb begin
      div_req.start = 1'b0;
      div_req.count = hhits_ff;
      div_req.size  = hbytes_ff;
      if ((state_ff == S_HWAIT || state_ff == S_DECIDE) && pol_ff != POL_GD)
         div_req.start = (state_ff == S_HWAIT) ? found_ff
                       : (free_ok_ff && !need[BYTES_W] && need[BYTES_W-1:0] <= cap_ff);
      if (state_ff == S_DECIDE) begin
         div_req.count = (pol_ff == POL_GDS) ? HITS_W'(1) : HITS_W'(1);
         div_req.size  = size_ff;
      end else if (pol_ff == POL_GDS) begin
         div_req.count = HITS_W'(1);
      end
   end

   // A register write takes precedence, so the request side holds off meanwhile.
   assign req_tready = (state_ff == S_IDLE) && !csr_valid;
   assign csr_ready  = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_RESP);
   assign rsp_tdata  = {7'd0, used_ff, evict_ff[EVICT_W-1:0], adm_ff, hit_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= '0;
         clk_ff   <= '0;
         used_ff  <= '0;
         cap_ff   <= '0;
         pol_ff   <= POL_GD;
         idx_ff   <= '0;
         rdv_ff   <= 1'b0;
      end else begin
         rdv_ff <= 1'b0;
         rd_ff  <= rd_slot;
         case (state_ff)
            S_IDLE: begin
               if (csr_valid) begin
                  if (csr_index == CSR_CAPACITY) cap_ff <= csr_data;
                  else pol_ff <= policy_type'(cfg_pol);
               end else if (req_tvalid) begin
                  id_ff    <= req_tdata[ID_W-1:0];
                  size_ff  <= req_tdata[ID_W+SIZE_W-1:ID_W];
                  hit_ff   <= 1'b0;
                  adm_ff   <= 1'b0;
                  evict_ff <= '0;
                  found_ff <= 1'b0;
                  idx_ff   <= '0;
                  state_ff <= S_HSCAN;
               end
            end
            S_HSCAN: begin
               // Issue one read per cycle; compare the previous read.
               if (rdv_ff && !found_ff && valid_ff[rd_ff] && r_obj == id_ff) begin
                  found_ff  <= 1'b1;
                  slot_ff   <= rd_ff;
                  hbytes_ff <= r_bytes;
                  hhits_ff  <= r_hits;
               end
               if (idx_ff == CNT_W'(ENTRIES)) state_ff <= S_HWAIT;
               else begin
                  rdv_ff <= 1'b1;
                  idx_ff <= idx_ff + CNT_W'(1);
               end
            end
            S_HWAIT: begin
               if (!found_ff) begin
                  idx_ff     <= '0;
                  vfound_ff  <= 1'b0;
                  free_ok_ff <= 1'b0;
                  state_ff   <= ({8'd0, size_ff} <= cap_ff) ? S_VSCAN : S_RESP;
               end else begin
                  hit_ff   <= 1'b1;
                  state_ff <= (pol_ff == POL_GD) ? S_HWRITE : S_HDIV;
               end
            end
            S_HDIV: if (div_rsp.done) state_ff <= S_HWRITE;
            S_HWRITE: begin
               mem_prio[slot_ff] <= new_prio;
               if (pol_ff == POL_GDSF && hhits_ff != '1)
                  mem_hits[slot_ff] <= hhits_ff + HITS_W'(1);
               state_ff <= S_RESP;
            end
            S_VSCAN: begin
               if (rdv_ff) begin
                  if (!valid_ff[rd_ff]) begin
                     if (!free_ok_ff) begin
                        free_ok_ff <= 1'b1;
                        free_ff    <= rd_ff;
                     end
                  end else if (!vfound_ff || r_prio < vprio_ff) begin
                     vfound_ff <= 1'b1;
                     vic_ff    <= rd_ff;
                     vprio_ff  <= r_prio;
                     vbytes_ff <= r_bytes;
                  end
               end
               if (idx_ff == CNT_W'(ENTRIES)) state_ff <= S_DECIDE;
               else begin
                  rdv_ff <= 1'b1;
                  idx_ff <= idx_ff + CNT_W'(1);
               end
            end
            S_DECIDE: begin
               if (free_ok_ff && !need[BYTES_W] && need[BYTES_W-1:0] <= cap_ff) begin
                  state_ff <= (pol_ff == POL_GD) ? S_IWRITE : S_IDIV;
               end else if (!vfound_ff) begin
                  state_ff <= S_RESP;
               end else begin
                  clk_ff   <= vprio_ff;
                  used_ff  <= (used_ff >= BYTES_W'(vbytes_ff))
                              ? used_ff - BYTES_W'(vbytes_ff) : '0;
                  valid_ff[vic_ff] <= 1'b0;
                  evict_ff <= evict_ff + CNT_W'(1);
                  idx_ff     <= '0;
                  vfound_ff  <= 1'b0;
                  free_ok_ff <= 1'b0;
                  state_ff   <= S_VSCAN;
               end
            end
            S_IDIV: if (div_rsp.done) state_ff <= S_IWRITE;
            S_IWRITE: begin
               valid_ff[free_ff]  <= 1'b1;
               mem_obj[free_ff]   <= id_ff;
               mem_bytes[free_ff] <= size_ff;
               mem_hits[free_ff]  <= HITS_W'(1);
               mem_prio[free_ff]  <= new_prio;
               used_ff  <= need[BYTES_W-1:0];
               adm_ff   <= 1'b1;
               state_ff <= S_RESP;
            end
            S_RESP: if (rsp_tready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// File: src/gdsf_div.sv
module gdsf_div
   import gdsf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int STEP_W = $clog2(DIVN_W + 1);

   logic [DIVN_W-1:0] num_ff, num_in;
   logic [SIZE_W:0]   rem_ff, rem_in;
   logic [SIZE_W-1:0] den_ff, den_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [SIZE_W:0]   trial;

   // One quotient bit per cycle, restoring division.
   always_comb begin
      num_in  = num_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = {rem_ff[SIZE_W-1:0], num_ff[DIVN_W-1]};
      if (div_req.start) begin
         num_in  = {div_req.count, {FRAC_BITS{1'b0}}};
         rem_in  = '0;
         den_in  = (div_req.size == '0) ? SIZE_W'(1) : div_req.size;
         step_in = STEP_W'(DIVN_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (trial >= {1'b0, den_ff}) begin
            rem_in = trial - {1'b0, den_ff};
            num_in = {num_ff[DIVN_W-2:0], 1'b1};
         end else begin
            rem_in = trial;
            num_in = {num_ff[DIVN_W-2:0], 1'b0};
         end
         step_in = step_ff - STEP_W'(1);
         if (step_ff == STEP_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      den_ff <= den_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = DIVQ_W'(num_ff);

endmodule

// File: src/gdsf_checker.sv
module gdsf_checker
   import gdsf_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic        csr_ready
);

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("request taken while result pending");

   a_hit_not_admit: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tdata[0] && rsp_tdata[1])) else $error("hit and admitted");

   a_hit_no_evict: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tdata[0]) |-> rsp_tdata[8:2] == 7'd0)
      else $error("evictions on a hit");

   a_busy_after_req: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready && !csr_ready)
      else $error("ready during work");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped");

endmodule

bind greedy_dual_size_freq_cache_core gdsf_checker u_gdsf_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
   .csr_ready(csr_ready)
);
